// File: rtl/lnps_pkg.sv
// Shared types, constants and the matrix-bit to key table for the
// last-note-priority key stack. No dependencies.
`timescale 1ns / 1ps

package lnps_pkg;

  localparam int KEY_BITS          = 30;  // width of one matrix scan
  localparam int NOTE_W            = 5;   // width of a key or note code
  localparam int NOTE_KEYS         = 25;  // keys 0..24 are notes
  localparam int BIT_W             = 5;   // index over the scan bits
  localparam int STACK_DEPTH_DEF   = 25;
  localparam int MATRIX_KEYS_DEF   = 30;
  localparam int IN_TDATA_W        = 32;
  localparam int OUT_TDATA_W       = 16;

  localparam logic [NOTE_W-1:0] NON_NOTE = 5'd31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_REL,
    S_SEARCH,
    S_TOP,
    S_DONE
  } lnps_state_e;

  // Matrix bit to key code; bits past the table read as a non-note key.
  function automatic logic [NOTE_W-1:0] key_of_bit(input logic [BIT_W-1:0] bit_idx);
    logic [NOTE_W-1:0] key;
    case (bit_idx)
      5'd0:    key = 5'd25;
      5'd1:    key = 5'd20;
      5'd2:    key = 5'd15;
      5'd3:    key = 5'd10;
      5'd4:    key = 5'd5;
      5'd5:    key = 5'd0;
      5'd6:    key = 5'd26;
      5'd7:    key = 5'd21;
      5'd8:    key = 5'd16;
      5'd9:    key = 5'd11;
      5'd10:   key = 5'd6;
      5'd11:   key = 5'd1;
      5'd12:   key = 5'd27;
      5'd13:   key = 5'd22;
      5'd14:   key = 5'd17;
      5'd15:   key = 5'd12;
      5'd16:   key = 5'd7;
      5'd17:   key = 5'd2;
      5'd18:   key = 5'd28;
      5'd19:   key = 5'd23;
      5'd20:   key = 5'd18;
      5'd21:   key = 5'd13;
      5'd22:   key = 5'd8;
      5'd23:   key = 5'd3;
      5'd24:   key = 5'd29;
      5'd25:   key = 5'd24;
      5'd26:   key = 5'd19;
      5'd27:   key = 5'd14;
      5'd28:   key = 5'd9;
      5'd29:   key = 5'd4;
      default: key = NON_NOTE;
    endcase
    return key;
  endfunction

endpackage

// File: rtl/lnps_stack.sv
// Held-note stack storage: one write port, one read port.
// Depends on lnps_pkg for the note width.
`timescale 1ns / 1ps

module lnps_stack #(
  parameter int DEPTH = lnps_pkg::STACK_DEPTH_DEF,
  parameter int IDX_W = 5
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_addr_i,
  input  logic [lnps_pkg::NOTE_W-1:0] wr_data_i,
  input  logic [IDX_W-1:0]            rd_addr_i,
  output logic [lnps_pkg::NOTE_W-1:0] rd_data_o
);
  import lnps_pkg::*;

  logic [NOTE_W-1:0] mem_q [DEPTH];

  // entries are only read below the fill depth, so no reset is needed
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_addr_i];

endmodule

// File: rtl/last_note_priority_stack.sv
// Last-note-priority key stack.
//
// Slave stream: one word per key-matrix scan, tdata[29:0] = key_bits.
// Master stream: one word per scan, tdata[4:0] = note_out, tdata[9:5] = held_count.
//
// A scan is compared with the previous one. A sequencer then walks the scan
// one bit per cycle: first pushing newly pressed notes, then, for each newly
// released note, walking the stack one entry per cycle to find and remove it,
// shifting later entries down. The stack top, if any, becomes the current note.
//
// With N = min(MATRIX_KEYS, 30), the push and release passes each cover N scan
// bits; the top of the stack is then read (S_TOP) and the word goes to the
// output register (S_DONE). Each released note adds a walk over the entries on
// the stack at that point, unless the stack is empty.
// s_axis_tready_o is high only while no scan is being worked on.
// The result sits in an output register; while the receiver stalls, the next
// scan is still taken and worked on, then waits until the register is free.
// Reset clears the previous scan, the stack depth and the note (lowest C).
`timescale 1ns / 1ps

module last_note_priority_stack #(
  parameter int STACK_DEPTH = lnps_pkg::STACK_DEPTH_DEF,
  parameter int MATRIX_KEYS = lnps_pkg::MATRIX_KEYS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [lnps_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // [29:0] key_bits
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [lnps_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o    // [4:0] note_out, [9:5] held_count
);
  import lnps_pkg::*;

  localparam int SCAN_BITS = (MATRIX_KEYS < KEY_BITS) ? MATRIX_KEYS : KEY_BITS;
  localparam int IDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);
  localparam int EXT_W     = (DEPTH_W > NOTE_W) ? DEPTH_W : NOTE_W;
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(SCAN_BITS - 1);

  lnps_state_e         state_q, state_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                found_q, found_d;
  logic [NOTE_W-1:0]   key_q, key_d;
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  logic [KEY_BITS-1:0] prev_q, prev_d;
  logic [KEY_BITS-1:0] cur_q, cur_d;
  logic [NOTE_W-1:0]   last_q, last_d;
  logic                out_valid_q, out_valid_d;
  logic [NOTE_W-1:0]   out_note_q, out_note_d;
  logic [NOTE_W-1:0]   out_count_q, out_count_d;

  logic [KEY_BITS-1:0] scan_mask;
  logic                in_fire;
  logic                out_free;
  logic                key_went_down;
  logic                key_went_up;
  logic [NOTE_W-1:0]   bit_key;
  logic                bit_is_note;
  logic                last_bit;
  logic                last_idx;
  logic                hit;
  logic [EXT_W-1:0]    depth_ext;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [NOTE_W-1:0]   wr_data;
  logic [IDX_W-1:0]    rd_addr;
  logic [NOTE_W-1:0]   rd_data;

  lnps_stack #(
    .DEPTH (STACK_DEPTH),
    .IDX_W (IDX_W)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    for (int b = 0; b < KEY_BITS; b++) begin
      scan_mask[b] = (b < SCAN_BITS);
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign key_went_down = cur_q[bit_q] && !prev_q[bit_q];
  assign key_went_up   = prev_q[bit_q] && !cur_q[bit_q];
  assign bit_key       = key_of_bit(bit_q);
  assign bit_is_note   = (bit_key < NOTE_W'(NOTE_KEYS));
  assign last_bit      = (bit_q == LAST_BIT);
  assign last_idx      = ((DEPTH_W'(idx_q) + DEPTH_W'(1)) == depth_q);
  assign hit           = (rd_data == key_q);
  assign depth_ext     = EXT_W'(depth_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (last_bit) state_d = S_REL;
      end
      S_REL: begin
        if (key_went_up && bit_is_note && depth_q != '0) state_d = S_SEARCH;
        else if (last_bit) state_d = S_TOP;
      end
      S_SEARCH: begin
        if (last_idx) state_d = last_bit ? S_TOP : S_REL;
      end
      S_TOP: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and stack port control
  always_comb begin
    bit_d       = bit_q;
    idx_d       = idx_q;
    found_d     = found_q;
    key_d       = key_q;
    depth_d     = depth_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_note_d  = out_note_q;
    out_count_d = out_count_q;
    wr_en       = 1'b0;
    wr_addr     = IDX_W'(depth_q);
    wr_data     = bit_key;
    rd_addr     = idx_q;

    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cur_d = s_axis_tdata_i[KEY_BITS-1:0] & scan_mask;
          bit_d = '0;
        end
      end
      S_PUSH: begin
        if (key_went_down && bit_is_note && depth_q < DEPTH_W'(STACK_DEPTH)) begin
          wr_en   = 1'b1;
          depth_d = depth_q + DEPTH_W'(1);
        end
        bit_d = last_bit ? '0 : bit_q + BIT_W'(1);
      end
      S_REL: begin
        if (key_went_up && bit_is_note && depth_q != '0) begin
          key_d   = bit_key;
          idx_d   = '0;
          found_d = 1'b0;
        end else if (!last_bit) begin
          bit_d = bit_q + BIT_W'(1);
        end
      end
      S_SEARCH: begin
        // after the match, each entry moves down one place
        if (found_q) begin
          wr_en   = 1'b1;
          wr_addr = idx_q - IDX_W'(1);
          wr_data = rd_data;
        end else if (hit) begin
          found_d = 1'b1;
        end
        if (last_idx) begin
          if (found_q || hit) depth_d = depth_q - DEPTH_W'(1);
          if (!last_bit) bit_d = bit_q + BIT_W'(1);
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_TOP: begin
        rd_addr = IDX_W'(depth_q - DEPTH_W'(1));
        if (depth_q != '0) last_d = rd_data;
        prev_d = cur_q;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_note_d  = last_q;
          out_count_d = depth_ext[NOTE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_q       <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      depth_q     <= '0;
      prev_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      depth_q     <= depth_d;
      prev_q      <= prev_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    cur_q       <= cur_d;
    out_note_q  <= out_note_d;
    out_count_q <= out_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - 2 * NOTE_W)'(0), out_count_q, out_note_q};

endmodule

// File: tb/tb_last_note_priority_stack.sv
// Testbench for last_note_priority_stack: streams key-matrix scans and checks
// each returned note/count word against an in-bench model of the held-note stack.
// Depends on rtl/lnps_pkg.sv, rtl/lnps_stack.sv and rtl/last_note_priority_stack.sv.
`timescale 1ns / 1ps

module tb_last_note_priority_stack;

  import lnps_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int RANDOM_SCANS   = 1050;

  localparam logic [KEY_BITS-1:0] DIRECTED_SCANS [17] = '{
    30'h0000_0000,
    30'h0000_0020,  // lowest note alone
    30'h0000_0000,
    30'h0104_1041,  // non-note keys only
    30'h0000_0000,
    30'h2000_0000,
    30'h2200_0000,  // highest note on top
    30'h3FFF_FFFF,  // every key down, stack full
    30'h3FFF_FFDF,  // release from the middle
    30'h1FFF_FFDF,  // release the bottom entry
    30'h0000_0000,  // nothing held, note kept
    30'h1555_5555,
    30'h2AAA_AAAA,  // press and release in one scan
    30'h3FFF_FFFF,
    30'h0200_0000,
    30'h0000_0001,
    30'h0000_0000
  };

  // Scoreboard: models the held-note stack and queues expected output words.
  class note_stack_sb;
    typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [NOTE_W-1:0] count;
    } note_word_t;

    note_word_t        pending_words[$];
    logic [NOTE_W-1:0] key_map[KEY_BITS];
    logic [NOTE_W-1:0] held[STACK_DEPTH_DEF];
    logic [KEY_BITS-1:0] prev_scan;
    int                depth;
    logic [NOTE_W-1:0] last_note;
    int                errors;

    function new();
      key_map = '{25, 20, 15, 10, 5, 0, 26, 21, 16, 11,
                  6, 1, 27, 22, 17, 12, 7, 2, 28, 23,
                  18, 13, 8, 3, 29, 24, 19, 14, 9, 4};
      prev_scan = '0;
      depth     = 0;
      last_note = '0;
      errors    = 0;
    endfunction

    function void drop_note(logic [NOTE_W-1:0] key);
      for (int i = 0; i < depth; i++) begin
        if (held[i] == key) begin
          for (int j = i; j + 1 < depth; j++) held[j] = held[j + 1];
          depth--;
          return;
        end
      end
    endfunction

    function void note_scan(logic [KEY_BITS-1:0] scan);
      logic [KEY_BITS-1:0] pressed;
      logic [KEY_BITS-1:0] released;
      note_word_t          w;
      pressed  = scan & ~prev_scan;
      released = prev_scan & ~scan;
      // pushes first, then removals, both in ascending bit order
      for (int b = 0; b < KEY_BITS; b++) begin
        if (pressed[b] && key_map[b] < NOTE_KEYS && depth < STACK_DEPTH_DEF) begin
          held[depth] = key_map[b];
          depth++;
        end
      end
      for (int b = 0; b < KEY_BITS; b++) begin
        if (released[b]) drop_note(key_map[b]);
      end
      if (depth > 0) last_note = held[depth - 1];
      prev_scan = scan;
      w.note    = last_note;
      w.count   = NOTE_W'(depth);
      pending_words.push_back(w);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] word);
      note_word_t w;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word %h", word));
      end else begin
        w = pending_words.pop_front();
        if (word[4:0] != w.note)
          report($sformatf("note_out %0d, want %0d", word[4:0], w.note));
        if (word[9:5] != w.count)
          report($sformatf("held_count %0d, want %0d", word[9:5], w.count));
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  note_stack_sb sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  logic [KEY_BITS-1:0] scan_now = '0;

  always #2 clk_i = ~clk_i;

  last_note_priority_stack dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // [29:0] key_bits
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)  // [4:0] note_out, [9:5] held_count
  );

  // Monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) sb.note_scan(s_tdata[KEY_BITS-1:0]);
      if (m_axis_tvalid_o && m_tready) sb.check_result(m_axis_tdata_o);
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb_last_note_priority_stack: errors");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task send_scan(logic [KEY_BITS-1:0] scan);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-KEY_BITS){1'b0}}, scan};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Mostly player-like changes to the held keys, some noise and extremes.
  function logic [KEY_BITS-1:0] next_scan(logic [KEY_BITS-1:0] cur);
    logic [KEY_BITS-1:0] s;
    int pick;
    s    = cur;
    pick = $urandom_range(99);
    if (pick < 55) begin
      repeat ($urandom_range(3, 1)) s[$urandom_range(KEY_BITS-1)] ^= 1'b1;
    end else if (pick < 70) begin
      repeat ($urandom_range(4, 1)) s[$urandom_range(KEY_BITS-1)] = 1'b1;
    end else if (pick < 80) begin
      repeat ($urandom_range(4, 1)) s[$urandom_range(KEY_BITS-1)] = 1'b0;
    end else if (pick < 88) begin
      s = KEY_BITS'($urandom);
    end else if (pick < 92) begin
      s = '0;
    end else if (pick < 95) begin
      s = '1;
    end else begin
      s = cur | KEY_BITS'($urandom);
    end
    return s;
  endfunction

  task run_random(int send_pct, int recv_pct, int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      scan_now = next_scan(scan_now);
      send_scan(scan_now);
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 45;
    foreach (DIRECTED_SCANS[i]) send_scan(DIRECTED_SCANS[i]);
    scan_now = DIRECTED_SCANS[$size(DIRECTED_SCANS)-1];

    // receiver holds off while scans keep coming, so the input backs up
    hold_left = HOLD_CYCLES;
    repeat (12) begin
      scan_now = next_scan(scan_now);
      send_scan(scan_now);
    end
    wait_drained();

    run_random(27, 45, RANDOM_SCANS / 3);
    run_random(45, 27, RANDOM_SCANS / 3);
    run_random(0, 0, RANDOM_SCANS - 2 * (RANDOM_SCANS / 3));

    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("tb_last_note_priority_stack: clean");
    end else begin
      $display("tb_last_note_priority_stack: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lnps_pkg.sv
rtl/lnps_stack.sv
rtl/last_note_priority_stack.sv
tb/tb_last_note_priority_stack.sv
